>>> rtl/cantm_pkg.sv
// ---------------------------------------------------------------------------
// CAN telemetry module table package
// Shared request, result and outcome types for the module table block.
// ---------------------------------------------------------------------------
package cantm_pkg;

    typedef enum logic [2:0] {
        OUT_CLEARED = 3'd0,
        OUT_IGNORED = 3'd1,
        OUT_SEEN    = 3'd2,
        OUT_VOLT    = 3'd3,
        OUT_CURR    = 3'd4,
        OUT_STATUS  = 3'd5,
        OUT_FULL    = 3'd6
    } t_outcome;

    localparam logic [3:0] PROTO_MODULE  = 4'h1;
    localparam logic [3:0] MSG_REPLY     = 4'h3;
    localparam logic [3:0] LEN_REPLY_MIN = 4'd2;
    localparam logic [3:0] LEN_VALUE_MIN = 4'd8;
    localparam logic [7:0] RC_VOLT       = 8'h00;
    localparam logic [7:0] RC_CURR       = 8'h01;
    localparam logic [7:0] RC_STATUS     = 8'h08;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPW         = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        t_outcome    op;
        logic [6:0]  addr;
        logic [31:0] value;
    } t_req;

    typedef struct packed {
        t_outcome    outcome;
        logic [2:0]  slot;
        logic [3:0]  count;
        logic [31:0] volt;
        logic [31:0] curr;
    } t_res;

endpackage

>>> rtl/cantm_front.sv
// ---------------------------------------------------------------------------
// CAN telemetry front end
// Accepts commands and frames, decodes protocol, address and reply type into
// a compact request, and holds it until the request queue takes it.
// ---------------------------------------------------------------------------
module cantm_front
    import cantm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic        i_cmd,
    input  logic [28:0] i_frame_id,
    input  logic [3:0]  i_frame_len,
    input  logic [7:0]  i_byte_zero,
    input  logic [7:0]  i_byte_one,
    input  logic [7:0]  i_byte_four,
    input  logic [7:0]  i_byte_five,
    input  logic [7:0]  i_byte_six,
    input  logic [7:0]  i_byte_seven,
    output logic        o_req_valid,
    input  logic        i_req_full,
    output t_req        o_req
);

    logic  r_valid, n_valid;
    t_req  r_req, n_req;
    logic  take;
    logic  is_reply;

    assign o_full      = r_valid && i_req_full;
    assign take        = i_push && !o_full;
    assign o_req_valid = r_valid;
    assign o_req       = r_req;
    assign is_reply    = (i_frame_len >= LEN_REPLY_MIN) && (i_byte_zero[3:0] == MSG_REPLY);

    always_comb begin
        n_req.addr  = i_frame_id[20:14];
        n_req.value = (i_frame_len >= LEN_VALUE_MIN) ?
                      {i_byte_four, i_byte_five, i_byte_six, i_byte_seven} : 32'd0;
        if (i_cmd) begin
            n_req.op = OUT_CLEARED;
        end else if (i_frame_id[28:25] != PROTO_MODULE || i_frame_id[20:14] == 7'd0) begin
            n_req.op = OUT_IGNORED;
        end else if (!is_reply) begin
            n_req.op = OUT_SEEN;
        end else begin
            case (i_byte_one)
                RC_VOLT:   n_req.op = OUT_VOLT;
                RC_CURR:   n_req.op = OUT_CURR;
                RC_STATUS: n_req.op = OUT_STATUS;
                default:   n_req.op = OUT_SEEN;
            endcase
        end
        n_valid = take || (r_valid && i_req_full);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_req <= n_req;
        end
    end

endmodule

>>> rtl/cantm_queue.sv
// ---------------------------------------------------------------------------
// CAN telemetry request queue
// Short first-in first-out buffer between the decoder and the table engine.
// ---------------------------------------------------------------------------
module cantm_queue
    import cantm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    output logic o_full,
    input  t_req i_data,
    output logic o_empty,
    input  logic i_pop,
    output t_req o_data
);

    t_req           r_mem [QUEUE_DEPTH];
    logic [QPW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QPW:0]   r_level, n_level;
    logic           do_push, do_pop;

    assign o_full  = (r_level == (QPW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_level == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + QPW'(1) : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + QPW'(1) : r_rd_ptr;
        n_level  = r_level + (QPW+1)'(do_push) - (QPW+1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_level  <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> rtl/cantm_back.sv
// ---------------------------------------------------------------------------
// CAN telemetry table engine
// Scans the address table one entry a cycle, appends new modules, stores
// slot zero readings and holds the result for the consumer.
// ---------------------------------------------------------------------------
module cantm_back
    import cantm_pkg::*;
#(
    parameter int TABLE_DEPTH = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_empty,
    output logic o_req_pop,
    input  t_req i_req,
    output logic o_empty,
    input  logic i_pop,
    output t_res o_res
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_PRIME = 3'b010,
        S_SCAN  = 3'b100
    } t_state;

    t_state        r_state, n_state;
    t_req          r_req, n_req;
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_raddr, n_raddr;
    logic [IW-1:0] r_cidx, n_cidx;
    logic [6:0]    r_rd;
    logic [31:0]   r_v0, n_v0;
    logic [31:0]   r_c0, n_c0;
    logic          r_out_valid, n_out_valid;
    t_res          r_out, n_out;
    logic [6:0]    r_addr_mem [TABLE_DEPTH];
    logic          wr_en;
    logic [IW-1:0] slot_idx;
    logic          fin, fin_found;

    assign o_empty   = !r_out_valid;
    assign o_res     = r_out;
    assign o_req_pop = (r_state == S_IDLE) && !i_req_empty && (!r_out_valid || i_pop);

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_count     = r_count;
        n_raddr     = r_raddr;
        n_cidx      = r_cidx;
        n_v0        = r_v0;
        n_c0        = r_c0;
        n_out_valid = r_out_valid && !i_pop;
        n_out       = r_out;
        wr_en       = 1'b0;
        slot_idx    = r_cidx;
        fin         = 1'b0;
        fin_found   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (o_req_pop) begin
                    n_req = i_req;
                    if (i_req.op == OUT_CLEARED) begin
                        n_count     = '0;
                        n_out_valid = 1'b1;
                        n_out       = '{OUT_CLEARED, 3'd0, 4'd0, r_v0, r_c0};
                    end else if (i_req.op == OUT_IGNORED) begin
                        n_out_valid = 1'b1;
                        n_out       = '{OUT_IGNORED, 3'd0, 4'(r_count), r_v0, r_c0};
                    end else begin
                        n_state = S_PRIME;
                        n_raddr = '0;
                    end
                end
            end
            S_PRIME: begin
                n_raddr = IW'(1);
                n_cidx  = '0;
                if (r_count == '0) begin
                    fin = 1'b1;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_rd == r_req.addr) begin
                    fin       = 1'b1;
                    fin_found = 1'b1;
                end else if (CW'(r_cidx) + CW'(1) == r_count) begin
                    fin = 1'b1;
                end else begin
                    n_cidx  = r_cidx + IW'(1);
                    n_raddr = r_cidx + IW'(2);
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (fin) begin
            n_state     = S_IDLE;
            n_out_valid = 1'b1;
            if (!fin_found && r_count == CW'(TABLE_DEPTH)) begin
                n_out = '{OUT_FULL, 3'd0, 4'(r_count), r_v0, r_c0};
            end else begin
                if (!fin_found) begin
                    slot_idx = r_count[IW-1:0];
                    wr_en    = 1'b1;
                    n_count  = r_count + CW'(1);
                end
                if (slot_idx == '0) begin
                    case (r_req.op)
                        OUT_VOLT: n_v0 = r_req.value;
                        OUT_CURR: n_c0 = r_req.value;
                        default:  ;
                    endcase
                end
                n_out = '{r_req.op, 3'(slot_idx), 4'(n_count), n_v0, n_c0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_v0        <= '0;
            r_c0        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_v0        <= n_v0;
            r_c0        <= n_c0;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_raddr <= n_raddr;
        r_cidx  <= n_cidx;
        r_out   <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_addr_mem[slot_idx] <= r_req.addr;
        end
        r_rd <= r_addr_mem[r_raddr];
    end

endmodule

>>> rtl/can_telemetry_module_table_top.sv
// ---------------------------------------------------------------------------
// CAN telemetry module table
// Tracks power modules seen on the bus and their slot zero readings.
// ---------------------------------------------------------------------------
// Each request gives exactly one result. Clear commands and ignored frames
// are answered in the idle state as they leave the queue head; a frame goes
// through the prime state and, if the table holds entries, the scan state,
// which searches the single-read-port address table one entry a cycle.
// A two-entry request queue and an input register let new requests enter
// while the engine scans, and the result register holds a finished result
// until it is popped. The table needs no clearing pass after reset.
module can_telemetry_module_table_top
    import cantm_pkg::*;
#(
    parameter int TABLE_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_cmd,
    input  logic [28:0] i_frame_id,
    input  logic [3:0]  i_frame_len,
    input  logic [7:0]  i_byte_zero,
    input  logic [7:0]  i_byte_one,
    input  logic [7:0]  i_byte_four,
    input  logic [7:0]  i_byte_five,
    input  logic [7:0]  i_byte_six,
    input  logic [7:0]  i_byte_seven,
    input  logic [31:0] i_now_ms,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_outcome,
    output logic [2:0]  o_slot,
    output logic [3:0]  o_module_count,
    output logic [31:0] o_first_voltage_mv,
    output logic [31:0] o_first_current_ma
);

    logic f_valid;
    t_req f_req;
    logic q_full, q_empty, q_pop;
    t_req q_req;
    t_res res;
    logic unused_now;

    assign unused_now = ^i_now_ms;

    cantm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_cmd        (i_cmd),
        .i_frame_id   (i_frame_id),
        .i_frame_len  (i_frame_len),
        .i_byte_zero  (i_byte_zero),
        .i_byte_one   (i_byte_one),
        .i_byte_four  (i_byte_four),
        .i_byte_five  (i_byte_five),
        .i_byte_six   (i_byte_six),
        .i_byte_seven (i_byte_seven),
        .o_req_valid  (f_valid),
        .i_req_full   (q_full),
        .o_req        (f_req)
    );

    cantm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .o_full  (q_full),
        .i_data  (f_req),
        .o_empty (q_empty),
        .i_pop   (q_pop),
        .o_data  (q_req)
    );

    cantm_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_empty (q_empty),
        .o_req_pop   (q_pop),
        .i_req       (q_req),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_res       (res)
    );

    assign o_outcome          = res.outcome;
    assign o_slot             = res.slot;
    assign o_module_count     = res.count;
    assign o_first_voltage_mv = res.volt;
    assign o_first_current_ma = res.curr;

`ifndef NO_ASSERTIONS
    a_clear_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_outcome == OUT_CLEARED) |-> (o_module_count == 4'd0))
        else $error("clear result with nonzero module count");

    a_none_slot : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_outcome == OUT_CLEARED || o_outcome == OUT_IGNORED ||
                    o_outcome == OUT_FULL)) |-> (o_slot == 3'd0))
        else $error("slot nonzero on result without module");

    a_full_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_outcome == OUT_FULL) |-> (o_module_count == 4'(TABLE_DEPTH)))
        else $error("table full reported below capacity");

    a_new_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && o_outcome == OUT_CLEARED) |=>
        (empty || o_outcome == OUT_CLEARED || o_outcome == OUT_IGNORED ||
         o_module_count <= 4'd1))
        else $error("module count grew by more than one after clear");
`endif

endmodule
